// ===== src/icyd_pkg.sv =====
// ----------------------------------------------------------------------------
// ICY deframer package
// Shared constants, prefix tables and the operation item that passes from
// the front part to the back part of the deframer.
// ----------------------------------------------------------------------------
package icyd_pkg;

  // Longest field value position tracked before saturation.
  localparam int MAX_FIELD_LEN_DEF = 256;

  // Depth of the operation queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic REG_ENABLE   = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  // Prefix lengths and special metadata bytes.
  localparam int         TITLE_LEN  = 12;
  localparam int         URL_LEN    = 10;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;

  // Operation codes. The first five equal the output kind codes.
  typedef enum logic [2:0] {
    OP_AUDIO     = 3'd0,
    OP_TITLE     = 3'd1,
    OP_URL       = 3'd2,
    OP_TITLE_END = 3'd3,
    OP_URL_END   = 3'd4,
    OP_BLOCK     = 3'd5
  } icyd_op_kind_t;

  // One queued operation.
  typedef struct packed {
    icyd_op_kind_t kind;
    logic [7:0]    data;
    logic          empty;
  } icyd_op_t;

  // "StreamTitle=" by position.
  function automatic logic [7:0] title_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "StreamUrl=" by position.
  function automatic logic [7:0] url_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h55; // U
      4'd7:    c = 8'h72; // r
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h3D; // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/icyd_front.sv =====
// ----------------------------------------------------------------------------
// ICY deframer front part
// Accepts stream bytes, tracks the audio/length/metadata framing and the
// field prefix match, and turns each byte into at most one queued operation.
// ----------------------------------------------------------------------------
module icyd_front
  import icyd_pkg::*;
#(
  parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_full,
  output logic        q_push,
  output icyd_op_t    q_op
);

  localparam int FPW = $clog2(MAX_FIELD_LEN + 1);

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  logic [15:0]      audio_count, audio_count_next;
  logic [11:0]      meta_left, meta_left_next;
  logic [FPW-1:0]   field_pos, field_pos_next;
  logic             title_match, title_match_next;
  logic             url_match, url_match_next;
  logic             metadata_enable;
  logic [15:0]      meta_interval;

  logic             accept;
  logic [11:0]      meta_dec;
  logic             tm_new, um_new;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  // A metadata byte never carries a stream start, so the count comes from the register.
  assign meta_dec = meta_left - 12'd1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      metadata_enable <= 1'b1;
      meta_interval   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:   metadata_enable <= cfg_data[0];
        REG_INTERVAL: meta_interval   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Per-byte classification and next framing state.
  always_comb begin
    phase_next       = phase;
    audio_count_next = audio_count;
    meta_left_next   = meta_left;
    field_pos_next   = field_pos;
    title_match_next = title_match;
    url_match_next   = url_match;
    q_push           = 1'b0;
    q_op.kind        = OP_AUDIO;
    q_op.data        = s_tdata;
    q_op.empty       = 1'b0;
    tm_new           = title_match;
    um_new           = url_match;

    // A stream start resets framing before the byte is taken.
    if (s_tuser) begin
      phase_next       = PH_AUDIO;
      audio_count_next = '0;
      meta_left_next   = '0;
      field_pos_next   = '0;
      title_match_next = 1'b1;
      url_match_next   = 1'b1;
    end

    case (phase_next)
      PH_LEN: begin
        // Length byte: the block starts and the weak count is cleared.
        meta_left_next   = {s_tdata, 4'h0};
        field_pos_next   = '0;
        title_match_next = 1'b1;
        url_match_next   = 1'b1;
        q_push           = 1'b1;
        q_op.kind        = OP_BLOCK;
        if (s_tdata == 8'h00) begin
          phase_next       = PH_AUDIO;
          audio_count_next = '0;
        end else begin
          phase_next = PH_META;
        end
      end
      PH_META: begin
        if (s_tdata == CHAR_SEMI) begin
          // Field end: report a matched field, then start a new one.
          q_op.data = 8'h00;
          if (title_match_next && field_pos_next >= FPW'(TITLE_LEN)) begin
            q_push     = 1'b1;
            q_op.kind  = OP_TITLE_END;
            q_op.empty = (field_pos_next == FPW'(TITLE_LEN));
          end else if (url_match_next && field_pos_next >= FPW'(URL_LEN)) begin
            q_push     = 1'b1;
            q_op.kind  = OP_URL_END;
            q_op.empty = (field_pos_next == FPW'(URL_LEN));
          end
          field_pos_next   = '0;
          title_match_next = 1'b1;
          url_match_next   = 1'b1;
        end else if (s_tdata != CHAR_QUOTE) begin
          // Field byte: extend the prefix match and emit value bytes.
          if (field_pos_next < FPW'(TITLE_LEN)) begin
            tm_new = title_match_next && (s_tdata == title_char(field_pos_next[3:0]));
          end else begin
            tm_new = title_match_next;
          end
          if (field_pos_next < FPW'(URL_LEN)) begin
            um_new = url_match_next && (s_tdata == url_char(field_pos_next[3:0]));
          end else begin
            um_new = url_match_next;
          end
          title_match_next = tm_new;
          url_match_next   = um_new;
          if (field_pos_next < FPW'(MAX_FIELD_LEN)) begin
            if (field_pos_next >= FPW'(TITLE_LEN) && tm_new) begin
              q_push    = 1'b1;
              q_op.kind = OP_TITLE;
            end else if (field_pos_next >= FPW'(URL_LEN) && um_new) begin
              q_push    = 1'b1;
              q_op.kind = OP_URL;
            end
            field_pos_next = field_pos_next + FPW'(1);
          end
        end
        meta_left_next = meta_dec;
        if (meta_dec == 12'd0) begin
          phase_next       = PH_AUDIO;
          audio_count_next = '0;
          field_pos_next   = '0;
          title_match_next = 1'b1;
          url_match_next   = 1'b1;
        end
      end
      default: begin
        // Audio byte, also for any unused phase code.
        phase_next = PH_AUDIO;
        q_push     = 1'b1;
        q_op.kind  = OP_AUDIO;
        if (metadata_enable && meta_interval != 16'd0 &&
            ({1'b0, audio_count_next} + 17'd1) >= {1'b0, meta_interval}) begin
          phase_next       = PH_LEN;
          audio_count_next = '0;
        end else begin
          audio_count_next = audio_count_next + 16'd1;
        end
      end
    endcase

    if (!accept) begin
      q_push = 1'b0;
    end
  end

  // Framing state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_AUDIO;
      audio_count <= '0;
      meta_left   <= '0;
      field_pos   <= '0;
      title_match <= 1'b1;
      url_match   <= 1'b1;
    end else if (accept) begin
      phase       <= phase_next;
      audio_count <= audio_count_next;
      meta_left   <= meta_left_next;
      field_pos   <= field_pos_next;
      title_match <= title_match_next;
      url_match   <= url_match_next;
    end
  end

endmodule

// ===== src/icyd_queue.sv =====
// ----------------------------------------------------------------------------
// ICY deframer operation queue
// Short first-in first-out store that decouples the front part from the
// back part so that either may stall on its own.
// ----------------------------------------------------------------------------
module icyd_queue
  import icyd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  icyd_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output icyd_op_t head_op
);

  icyd_op_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== src/icyd_back.sv =====
// ----------------------------------------------------------------------------
// ICY deframer back part
// Carries out queued operations: keeps the per-block weak count and drives
// the registered result stream.
// ----------------------------------------------------------------------------
module icyd_back
  import icyd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  icyd_op_t    head_op,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [3:0]  m_tuser
);

  logic [7:0] empty_count;
  logic [7:0] empty_count_next;
  logic       is_block;
  logic       out_free;

  assign is_block = (head_op.kind == OP_BLOCK);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = head_valid && (is_block || out_free);

  // Weak count after this operation.
  always_comb begin
    empty_count_next = empty_count;
    case (head_op.kind)
      OP_BLOCK:                empty_count_next = 8'h00;
      OP_TITLE_END, OP_URL_END: begin
        if (head_op.empty) begin
          empty_count_next = empty_count + 8'd1;
        end
      end
      default:                 ;
    endcase
  end

  // Weak count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_count <= '0;
    end else if (pop) begin
      empty_count <= empty_count_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && !is_block) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload; the operation code doubles as the output kind.
  always_ff @(posedge clk) begin
    if (pop && !is_block) begin
      m_tdata <= {empty_count_next, head_op.data};
      m_tuser <= {head_op.empty, 3'(head_op.kind)};
    end
  end

endmodule

// ===== src/icy_metadata_deframer.sv =====
// ----------------------------------------------------------------------------
// ICY metadata deframer
// Splits a received stream body into audio bytes and tagged title and url
// metadata values, with field end reports and a per-block weak count.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_tvalid/s_tready  tdata: stream_byte; tuser: stream_start
//   m_       out        m_tvalid/m_tready  tdata: out_byte, weak_count;
//                                          tuser: out_kind, value_empty
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// One byte is accepted every cycle while the queue is not full; a result
// reaches the master port through the queue entry written at the accepting
// edge and then through the output register.
// The four-entry operation queue lets the front keep accepting while the
// output is stalled; s_tready falls only when the queue is full.
// Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module icy_metadata_deframer
  import icyd_pkg::*;
#(
  parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tuser,   // [0] stream_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] weak_count
  output logic [3:0]  m_tuser,   // [2:0] out_kind, [3] value_empty
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic     q_full;
  logic     q_push;
  icyd_op_t q_op;
  logic     q_pop;
  logic     head_valid;
  icyd_op_t head_op;

  // Framing and field classification.
  icyd_front #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_op)
  );

  // Operation queue.
  icyd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Weak count and result output.
  icyd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
